>>> src/cmib_pkg.sv
// Shared types, codes and constants for the cartridge mapper block.
`default_nettype none
package cmib_pkg;

	// Item commands
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_CYCLES = 2'd1;
	localparam logic [1:0] CMD_LINE   = 2'd2;

	// Mapper register indexes (low address nibble)
	localparam logic [3:0] REG_CHR_LAST  = 4'd7;
	localparam logic [3:0] REG_OUTER_LOW = 4'd3;
	localparam logic [3:0] REG_PRG       = 4'd8;
	localparam logic [3:0] REG_MIRROR    = 4'd9;
	localparam logic [3:0] REG_IRQ_CTRL  = 4'd10;
	localparam logic [3:0] REG_LATCH_LO  = 4'd11;
	localparam logic [3:0] REG_LATCH_HI  = 4'd12;

	// Configuration register indexes
	localparam logic [1:0] CFG_VARIANT = 2'd0;
	localparam logic [1:0] CFG_SOURCE  = 2'd1;
	localparam logic [1:0] CFG_BANKS   = 2'd2;
	localparam logic [1:0] CFG_CHR     = 2'd3;

	localparam logic [10:0] BANKS_RESET = 11'd16;
	localparam logic [15:0] LINE_CYCLES = 16'd113;
	localparam logic [4:0]  ALT_FIXED_LO = 5'h1E;
	localparam logic [4:0]  ALT_FIXED_HI = 5'h1F;

	typedef struct packed {
		logic [1:0] command;
		logic       high_area;
		logic [3:0] reg_index;
		logic [7:0] wdata;
		logic [7:0] cycles;
	} item_t;

	typedef struct packed {
		logic       irq_out;
		logic [9:0] prg_bank_8000;
		logic [9:0] prg_bank_a000;
		logic [9:0] prg_bank_c000;
		logic [9:0] prg_bank_e000;
		logic [1:0] mirror_mode;
		logic       chr_write;
		logic [2:0] chr_slot;
		logic [7:0] chr_bank;
	} result_t;

	typedef struct packed {
		logic        board_variant;
		logic        irq_source;
		logic [10:0] prg_rom_banks_8k;
		logic        chr_rom_present;
	} cfg_t;

endpackage
`default_nettype wire

>>> src/cmib_irq.sv
// IRQ latch, counter, enable and line, updated once per word.
`default_nettype none
module cmib_irq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire cmib_pkg::item_t item,
	input  wire cmib_pkg::cfg_t  cfg,
	output logic                line_next
);

	logic        enabled_q;
	logic [15:0] count_q;
	logic [15:0] reload_q;
	logic        line_q;

	logic        enabled_n;
	logic [15:0] count_n;
	logic [15:0] reload_n;
	logic        wr_active;
	logic        std;
	logic [15:0] cyc16;

	assign std       = !cfg.board_variant;
	assign wr_active = (item.command == cmib_pkg::CMD_WRITE) && (std || item.high_area);
	assign cyc16     = {8'd0, item.cycles};

	always_comb begin
		enabled_n = enabled_q;
		count_n   = count_q;
		reload_n  = reload_q;
		line_next = line_q;
		case (item.command)
			cmib_pkg::CMD_WRITE: begin
				if (wr_active) begin
					if (item.reg_index == cmib_pkg::REG_IRQ_CTRL) begin
						enabled_n = item.wdata[0];
						count_n   = reload_q;
						line_next = 1'b0;
					end else if (item.reg_index == cmib_pkg::REG_LATCH_LO) begin
						reload_n = {reload_q[15:8], item.wdata};
						// standard board loads the counter along with the latch
						if (std) count_n = {count_q[15:8], item.wdata};
					end else if (item.reg_index == cmib_pkg::REG_LATCH_HI) begin
						reload_n = {item.wdata, reload_q[7:0]};
						if (std) count_n = {item.wdata, count_q[7:0]};
					end
				end
			end
			cmib_pkg::CMD_CYCLES: begin
				if (!cfg.irq_source && enabled_q) begin
					if (count_q <= cyc16) line_next = 1'b1;
					count_n = count_q - cyc16;
				end
			end
			cmib_pkg::CMD_LINE: begin
				if (cfg.irq_source && enabled_q) begin
					// hold the counter once it reaches the last line
					if (count_q <= cmib_pkg::LINE_CYCLES) line_next = 1'b1;
					else count_n = count_q - cmib_pkg::LINE_CYCLES;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			count_q   <= 16'd0;
			reload_q  <= 16'd0;
			line_q    <= 1'b0;
		end else if (fire) begin
			enabled_q <= enabled_n;
			count_q   <= count_n;
			reload_q  <= reload_n;
			line_q    <= line_next;
		end
	end

endmodule
`default_nettype wire

>>> src/cmib_bank.sv
// PRG bank map, outer/inner selects, mirroring and CHR update decode.
`default_nettype none
module cmib_bank (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire cmib_pkg::item_t item,
	input  wire cmib_pkg::cfg_t  cfg,
	input  wire logic            layout_load,
	input  wire logic [10:0]     layout_banks,
	output logic [9:0]           prg_next [4],
	output logic [1:0]           mirror_next,
	output logic                 chr_write,
	output logic [2:0]           chr_slot,
	output logic [7:0]           chr_bank
);

	logic [9:0] prg_q [4];
	logic [7:0] sel_q;
	logic       outer_low_q;
	logic       outer_high_q;
	logic [1:0] mirror_q;

	logic [7:0] sel_n;
	logic       outer_low_n;
	logic       outer_high_n;
	logic [9:0] low_base;
	logic [9:0] high_base;
	logic       is_wr;
	logic       std;
	logic       alt_wr;

	assign std    = !cfg.board_variant;
	assign is_wr  = item.command == cmib_pkg::CMD_WRITE;
	assign alt_wr = is_wr && !std && item.high_area;

	always_comb begin
		sel_n        = sel_q;
		outer_low_n  = outer_low_q;
		outer_high_n = outer_high_q;
		if (alt_wr) begin
			if (item.reg_index <= cmib_pkg::REG_OUTER_LOW) outer_low_n = item.wdata[0];
			else if (item.reg_index <= cmib_pkg::REG_CHR_LAST) outer_high_n = item.wdata[0];
			else if (item.reg_index == cmib_pkg::REG_PRG) sel_n = item.wdata;
		end
	end

	assign low_base  = {1'b0, sel_n, 1'b0} + {4'd0, outer_low_n, 5'd0};
	assign high_base = {4'd0, outer_high_n, 5'd0};

	always_comb begin
		prg_next    = prg_q;
		mirror_next = mirror_q;
		chr_write   = 1'b0;
		chr_slot    = 3'd0;
		chr_bank    = 8'd0;
		if (is_wr && std) begin
			if (item.reg_index <= cmib_pkg::REG_CHR_LAST) begin
				if (cfg.chr_rom_present) begin
					chr_write = 1'b1;
					chr_slot  = item.reg_index[2:0];
					chr_bank  = item.wdata;
				end
			end else if (item.reg_index == cmib_pkg::REG_PRG) begin
				prg_next[0] = {1'b0, item.wdata, 1'b0};
				prg_next[1] = {1'b0, item.wdata, 1'b1};
			end else if (item.reg_index == cmib_pkg::REG_MIRROR) begin
				mirror_next = item.wdata[1:0];
			end
		end else if (alt_wr) begin
			if (item.reg_index <= cmib_pkg::REG_OUTER_LOW) begin
				prg_next[0] = low_base;
				prg_next[1] = low_base + 10'd1;
			end else if (item.reg_index <= cmib_pkg::REG_CHR_LAST) begin
				prg_next[2] = high_base | {5'd0, cmib_pkg::ALT_FIXED_LO};
				prg_next[3] = high_base | {5'd0, cmib_pkg::ALT_FIXED_HI};
			end else if (item.reg_index == cmib_pkg::REG_PRG) begin
				prg_next[0] = low_base;
				prg_next[1] = low_base + 10'd1;
				prg_next[2] = high_base | {5'd0, cmib_pkg::ALT_FIXED_LO};
				prg_next[3] = high_base | {5'd0, cmib_pkg::ALT_FIXED_HI};
			end else if (item.reg_index == cmib_pkg::REG_MIRROR) begin
				mirror_next = item.wdata[1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_q[0]     <= 10'd0;
			prg_q[1]     <= 10'd1;
			prg_q[2]     <= cmib_pkg::BANKS_RESET[9:0] - 10'd2;
			prg_q[3]     <= cmib_pkg::BANKS_RESET[9:0] - 10'd1;
			sel_q        <= 8'd0;
			outer_low_q  <= 1'b0;
			outer_high_q <= 1'b0;
			mirror_q     <= 2'd0;
		end else if (layout_load) begin
			// reload the power-on layout for the new ROM size
			prg_q[0] <= 10'd0;
			prg_q[1] <= 10'd1;
			prg_q[2] <= layout_banks[9:0] - 10'd2;
			prg_q[3] <= layout_banks[9:0] - 10'd1;
		end else if (fire) begin
			prg_q        <= prg_next;
			sel_q        <= sel_n;
			outer_low_q  <= outer_low_n;
			outer_high_q <= outer_high_n;
			mirror_q     <= mirror_next;
		end
	end

endmodule
`default_nettype wire

>>> src/cartridge_mapper_irq_banking.sv
// Top level of the cartridge mapper: input register, mapper state, result register.
`default_nettype none
// Each word (a register write, a batch of CPU-cycle ticks or one scanline tick)
// yields exactly one result word. A word is taken into an input register; when
// the result register is free or being taken, the IRQ and banking logic updates
// the mapper state and fills the result register, so the block sustains one word
// per clock while each result is taken at once. The result register lets a new
// word in while the previous result waits. Configuration writes are taken at
// any time (cfg_ready is always high) and must be made only while the block is
// idle; writing prg_rom_banks_8k reloads the PRG layout for the new size.
module cartridge_mapper_irq_banking (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire cmib_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output cmib_pkg::result_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [10:0]       cfg_data
);

	cmib_pkg::cfg_t    cfg_q;
	cmib_pkg::item_t   item_s1;
	logic              valid_s1;
	cmib_pkg::result_t result_q;
	logic              result_valid_q;

	logic              advance;
	logic              cfg_wr;
	logic              line_next;
	logic [9:0]        prg_next [4];
	logic [1:0]        mirror_next;
	logic              chr_write;
	logic [2:0]        chr_slot;
	logic [7:0]        chr_bank;

	assign cfg_ready    = 1'b1;
	assign cfg_wr       = cfg_valid && cfg_ready;
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.board_variant    <= 1'b0;
			cfg_q.irq_source       <= 1'b0;
			cfg_q.prg_rom_banks_8k <= cmib_pkg::BANKS_RESET;
			cfg_q.chr_rom_present  <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_index)
				cmib_pkg::CFG_VARIANT: cfg_q.board_variant    <= cfg_data[0];
				cmib_pkg::CFG_SOURCE:  cfg_q.irq_source       <= cfg_data[0];
				cmib_pkg::CFG_BANKS:   cfg_q.prg_rom_banks_8k <= cfg_data;
				cmib_pkg::CFG_CHR:     cfg_q.chr_rom_present  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) item_s1 <= item;
	end

	cmib_irq u_irq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item_s1),
		.cfg       (cfg_q),
		.line_next (line_next)
	);

	cmib_bank u_bank (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.item         (item_s1),
		.cfg          (cfg_q),
		.layout_load  (cfg_wr && (cfg_index == cmib_pkg::CFG_BANKS)),
		.layout_banks (cfg_data),
		.prg_next     (prg_next),
		.mirror_next  (mirror_next),
		.chr_write    (chr_write),
		.chr_slot     (chr_slot),
		.chr_bank     (chr_bank)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.irq_out       <= line_next;
			result_q.prg_bank_8000 <= prg_next[0];
			result_q.prg_bank_a000 <= prg_next[1];
			result_q.prg_bank_c000 <= prg_next[2];
			result_q.prg_bank_e000 <= prg_next[3];
			result_q.mirror_mode   <= mirror_next;
			result_q.chr_write     <= chr_write;
			result_q.chr_slot      <= chr_slot;
			result_q.chr_bank      <= chr_bank;
		end
	end

endmodule
`default_nettype wire

>>> src/cmib_checker.sv
// Port-level checks for the cartridge mapper, bound to the top level.
`default_nettype none
module cmib_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire cmib_pkg::result_t result,
	input wire logic              cfg_valid,
	input wire logic              cfg_ready
);

	// a pending result stays up until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before it was taken");

	// the bank at A000h always directly follows the bank at 8000h
	a_low_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.prg_bank_a000 == result.prg_bank_8000 + 10'd1)
		else $error("low PRG bank pair broken");

	a_high_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.prg_bank_e000 == result.prg_bank_c000 + 10'd1)
		else $error("high PRG bank pair broken");

	// CHR fields are zero unless a CHR bank was written
	a_chr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.chr_write |-> result.chr_slot == 3'd0 &&
			result.chr_bank == 8'd0)
		else $error("CHR fields set without a CHR write");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind cartridge_mapper_irq_banking cmib_checker u_cmib_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);
`default_nettype wire
